### rtl/rbd_pkg.sv
package rbd_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK       = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  // Per-step decisions handed from the pointer logic to the top level.
  typedef struct packed {
    logic    we;
    logic    fwd_front;
    logic    fwd_back;
    logic    empty;
    status_e status;
  } step_flags_t;

endpackage

### rtl/rbd_if.sv
interface rbd_req_if
  import rbd_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
);
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WIDTH-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface rbd_rsp_if
  import rbd_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF,
  parameter int unsigned CW    = $clog2(DEPTH_DEF + 1)
);
  logic                valid;
  logic                ready;
  logic [WIDTH-1:0]    front_value;
  logic [WIDTH-1:0]    back_value;
  logic [CW-1:0]       count;
  logic                empty_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output front_value, output back_value, output count,
                  output empty_res, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input empty_res, input status, output ready);
endinterface

### rtl/ring_buffer_deque.sv
// Channel   Dir  Modport  Payload
// req_i     in   sink     func, value
// rsp_o     out  source   front_value, back_value, count, empty_res, status
//
// On accept the block updates head and count, writes the pushed entry and
// reads the new front and back entries into the RAM read register; once the
// output slot is free or being taken, the read data moves into the output
// register. No new request is taken while one waits in the RAM read register.
// Reset clears head, count and the handshake state; the store needs no clear.
// A result waiting in the output register does not block the next request;
// a second one parks in the RAM read register until the output drains.
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned WIDTH = WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rbd_req_if.sink   req_i,
  rbd_rsp_if.source rsp_o
);

  // Pointer state.
  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q;

  // Pending stage: a request whose RAM reads are in flight or parked.
  logic             pend_q;
  step_flags_t      flags_q;
  logic [WIDTH-1:0] wdata_q;
  logic [CW-1:0]    pcount_q;

  // Output register.
  logic                out_valid_q;
  logic [WIDTH-1:0]    front_q, back_q;
  logic [CW-1:0]       ocount_q;
  logic                oempty_q;
  logic [STATUS_W-1:0] ostatus_q;

  logic [AW-1:0]    head_d, waddr, raddr_front, raddr_back;
  logic [CW-1:0]    count_d;
  step_flags_t      flags_d;
  logic [WIDTH-1:0] rdata_front, rdata_back, front_d, back_d;
  logic             accept, drain;

  assign req_i.ready = !pend_q;
  assign accept      = req_i.valid && req_i.ready;
  // Move the pending result on when the output slot is free or being taken.
  assign drain       = pend_q && (!out_valid_q || rsp_o.ready);

  rbd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .head_i       (head_q),
    .count_i      (count_q),
    .func_i       (req_i.func),
    .head_o       (head_d),
    .count_o      (count_d),
    .waddr_o      (waddr),
    .raddr_front_o(raddr_front),
    .raddr_back_o (raddr_back),
    .flags_o      (flags_d)
  );

  rbd_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (accept && flags_d.we),
    .waddr_i  (waddr),
    .wdata_i  (req_i.value),
    .re_i     (accept),
    .raddr_a_i(raddr_front),
    .raddr_b_i(raddr_back),
    .rdata_a_o(rdata_front),
    .rdata_b_o(rdata_back)
  );

  // Forward the pushed value over the stale RAM read; force zero when empty.
  always_comb begin
    priority if (flags_q.empty) begin
      front_d = '0;
      back_d  = '0;
    end else begin
      front_d = flags_q.fwd_front ? wdata_q : rdata_front;
      back_d  = flags_q.fwd_back  ? wdata_q : rdata_back;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
        pend_q  <= 1'b1;
      end else if (drain) begin
        pend_q  <= 1'b0;
      end
      if (drain) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture on accept, advance on drain.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q  <= flags_d;
      wdata_q  <= req_i.value;
      pcount_q <= count_d;
    end
    if (drain) begin
      front_q   <= front_d;
      back_q    <= back_d;
      ocount_q  <= pcount_q;
      oempty_q  <= flags_q.empty;
      ostatus_q <= flags_q.status;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;
  assign rsp_o.count       = ocount_q;
  assign rsp_o.empty_res   = oempty_q;
  assign rsp_o.status      = ostatus_q;

endmodule

### rtl/rbd_ram.sv
module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the old contents on an address collision; hold data when idle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

### rtl/rbd_ctrl.sv
module rbd_ctrl
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned SW   = AW + 1
) (
  input  logic [AW-1:0]     head_i,
  input  logic [CW-1:0]     count_i,
  input  logic [FUNC_W-1:0] func_i,
  output logic [AW-1:0]     head_o,
  output logic [CW-1:0]     count_o,
  output logic [AW-1:0]     waddr_o,
  output logic [AW-1:0]     raddr_front_o,
  output logic [AW-1:0]     raddr_back_o,
  output step_flags_t       flags_o
);

  logic          full, none;
  logic [AW-1:0] head_dec, head_inc, tail;
  logic [SW-1:0] tail_sum, back_sum;
  logic          we, fwd_front, fwd_back, empty;
  status_e       status;

  assign full = (count_i == CW'(DEPTH));
  assign none = (count_i == '0);

  assign head_dec = (head_i == '0) ? AW'(DEPTH - 1) : head_i - AW'(1);
  assign head_inc = (head_i == AW'(DEPTH - 1)) ? '0 : head_i + AW'(1);

  // Sum stays below twice the depth: one compare and subtract wraps it.
  assign tail_sum = SW'(head_i) + SW'(count_i);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  always_comb begin
    head_o  = head_i;
    count_o = count_i;
    waddr_o = tail;
    we      = 1'b0;
    status  = STATUS_OK;
    unique case (func_i)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status = STATUS_OVERFLOW;
        end else begin
          head_o  = head_dec;
          waddr_o = head_dec;
          count_o = count_i + CW'(1);
          we      = 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          status = STATUS_OVERFLOW;
        end else begin
          count_o = count_i + CW'(1);
          we      = 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (none) begin
          status = STATUS_UNDERFLOW;
        end else begin
          head_o  = head_inc;
          count_o = count_i - CW'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (none) begin
          status = STATUS_UNDERFLOW;
        end else begin
          count_o = count_i - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Back entry after the step; meaningless when the deque ends up empty.
  assign back_sum      = SW'(head_o) + SW'(count_o) - SW'(1);
  assign raddr_front_o = head_o;
  assign raddr_back_o  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                  : AW'(back_sum);

  // The entry just written is not yet visible at the RAM read port.
  assign fwd_front = we && (waddr_o == raddr_front_o);
  assign fwd_back  = we && (waddr_o == raddr_back_o);
  assign empty     = (count_o == '0);

  assign flags_o = '{we: we, fwd_front: fwd_front, fwd_back: fwd_back,
                     empty: empty, status: status};

endmodule
